// ----- design/rwle_pkg.sv -----
// ----------------------------------------------------------------------------
// rwle_pkg: shared types and constants of the ripple LED envelope engine
// Field widths, register reset values, register indexes, command codes and
// the state types of the sequencer and of the envelope unit.
// ----------------------------------------------------------------------------
package rwle_pkg;

	// Field widths.
	localparam int TIME_W     = 32;
	localparam int LEVEL_W    = 8;
	localparam int DUR_W      = 16;
	localparam int CENTER_W   = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int OUT_LEDS   = 3;

	// Quotient bits produced by the envelope divider, one per cycle.
	localparam int QUO_W = 8;
	localparam int QCNT_W = $clog2(QUO_W);
	// Width of the product of elapsed time and peak brightness.
	localparam int PROD_W = DUR_W + LEVEL_W;

	// Default sizes of the wave ring and the LED row.
	localparam int WAVE_SLOTS_DEF = 8;
	localparam int LED_COUNT_DEF  = 3;

	// Register reset values.
	localparam logic [LEVEL_W-1:0] MAX_BRIGHTNESS_RST = 8'd255;
	localparam logic [DUR_W-1:0]   WAVE_DURATION_RST  = 16'd500;
	localparam logic [DUR_W-1:0]   STEP_DELAY_RST     = 16'd100;

	// Register indexes on the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_MAX_BRIGHTNESS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WAVE_DURATION  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_STEP_DELAY     = 2'd2;

	// Command codes of an input word.
	localparam logic CMD_TICK  = 1'b0;
	localparam logic CMD_PRESS = 1'b1;

	// One entry of the per-LED store: live flag and start time.
	typedef struct packed {
		logic              live;
		logic [TIME_W-1:0] start;
	} cell_t;

	// Status of the envelope unit as seen by the sequencer.
	typedef struct packed {
		logic busy;
		logic done;
	} env_stat_t;

	// Main sequencer states.
	typedef enum logic [2:0] {
		S_IDLE,
		S_PRESS,
		S_WAVE,
		S_READ,
		S_EVAL,
		S_ENV,
		S_DONE
	} seq_state_t;

	// Envelope unit states.
	typedef enum logic [1:0] {
		E_IDLE,
		E_MUL,
		E_DIV,
		E_FIN
	} env_state_t;

endpackage

// ----- design/rwle_if.sv -----
// ----------------------------------------------------------------------------
// rwle_if: channel interfaces of the ripple LED envelope engine
// Input item channel, result channel and configuration write channel, each
// with valid, ready and payload.
// ----------------------------------------------------------------------------

// Input items: ticks and key presses.
interface rwle_item_if;
	logic                             valid;
	logic                             ready;
	logic                             cmd;
	logic [rwle_pkg::TIME_W-1:0]      now_ms;
	logic [rwle_pkg::CENTER_W-1:0]    center;
	logic [rwle_pkg::LEVEL_W-1:0]     base_level_0;
	logic [rwle_pkg::LEVEL_W-1:0]     base_level_1;
	logic [rwle_pkg::LEVEL_W-1:0]     base_level_2;

	modport source (output valid, cmd, now_ms, center, base_level_0, base_level_1,
		base_level_2, input ready);
	modport sink (input valid, cmd, now_ms, center, base_level_0, base_level_1,
		base_level_2, output ready);
endinterface

// Result words: one set of LED levels per tick.
interface rwle_result_if;
	logic                         valid;
	logic                         ready;
	logic [rwle_pkg::LEVEL_W-1:0] level_0;
	logic [rwle_pkg::LEVEL_W-1:0] level_1;
	logic [rwle_pkg::LEVEL_W-1:0] level_2;

	modport source (output valid, level_0, level_1, level_2, input ready);
	modport sink (input valid, level_0, level_1, level_2, output ready);
endinterface

// Register writes.
interface rwle_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [rwle_pkg::CFG_IDX_W-1:0]  index;
	logic [rwle_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ----- design/ripple_wave_led_envelope.sv -----
// ----------------------------------------------------------------------------
// ripple_wave_led_envelope: ripple light engine for a row of LEDs
// Press words store a wave in a ring of slots; tick words walk all waves,
// evaluate each LED's triangular envelope and return the peak per LED.
// ----------------------------------------------------------------------------
// Press: each LED of the wave is written in turn, then the block returns to idle
// to take the next word. Tick: every slot is visited, each LED of a live wave is
// read and checked, and each lit LED runs through the shared unit (no divide when
// half the duration is zero).
// A finished result waits in the output register while new words come in.
// Reset restores register defaults, clears all wave flags and the ring
// pointer; the LED store needs no clearing pass.
module ripple_wave_led_envelope #(
	parameter int WAVE_SLOTS = rwle_pkg::WAVE_SLOTS_DEF,
	parameter int LED_COUNT  = rwle_pkg::LED_COUNT_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	rwle_item_if.sink    item,
	rwle_result_if.source result,
	rwle_cfg_if.sink     cfg
);
	import rwle_pkg::*;

	localparam int CELLS  = WAVE_SLOTS * LED_COUNT;
	localparam int SLOT_W = (WAVE_SLOTS > 1) ? $clog2(WAVE_SLOTS) : 1;
	localparam int LED_W  = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
	localparam int CELL_W = (CELLS > 1) ? $clog2(CELLS) : 1;
	localparam int DIST_W = (LED_W > CENTER_W) ? LED_W : CENTER_W;

	seq_state_t state_q, state_d;

	// Configuration registers.
	logic [LEVEL_W-1:0] mb_q;
	logic [DUR_W-1:0]   dur_q;
	logic [DUR_W-1:0]   step_q;

	// Latched input word.
	logic                cmd_q;
	logic [TIME_W-1:0]   now_q;
	logic [CENTER_W-1:0] center_q;
	logic [LEVEL_W-1:0]  base_q [OUT_LEDS];

	// Walk counters and wave state.
	logic [SLOT_W-1:0]     slot_q;
	logic [LED_W-1:0]      led_q;
	logic [CELL_W-1:0]     cell_q;
	logic                  any_on_q;
	logic [WAVE_SLOTS-1:0] wave_live_q;
	logic [SLOT_W-1:0]     next_slot_q;
	logic [CELL_W-1:0]     next_base_q;

	// Per-LED peak of the current tick and the output register.
	logic [LEVEL_W-1:0] level_q [LED_COUNT];
	logic [LEVEL_W-1:0] out_level_q [OUT_LEDS];
	logic [LEVEL_W-1:0] out_level_d [OUT_LEDS];
	logic               out_valid_q;

	// Sequencer decodes.
	logic item_ready;
	logic last_led;
	logic last_slot;
	logic out_free;
	logic mem_we;
	logic mem_re;
	logic env_start;
	logic adv;
	logic load_out;

	// LED store access.
	cell_t mem_wdata;
	cell_t mem_rdata;

	// Evaluation of one stored LED.
	logic [TIME_W-1:0]        elapsed;
	logic                     started;
	logic                     expire;
	logic                     lit;
	logic [DIST_W-1:0]        center_x;
	logic [DIST_W-1:0]        led_x;
	logic [DIST_W-1:0]        led_gap;
	logic [DIST_W+DUR_W-1:0]  delay;
	logic [TIME_W-1:0]        press_start;

	env_stat_t          env_stat;
	logic [LEVEL_W-1:0] env_value;

	assign last_led  = led_q == LED_W'(LED_COUNT - 1);
	assign last_slot = slot_q == SLOT_W'(WAVE_SLOTS - 1);
	assign out_free  = !out_valid_q || result.ready;

	// Start time of a pressed LED: press time plus distance from the key times the step delay.
	assign center_x    = DIST_W'(center_q);
	assign led_x       = DIST_W'(led_q);
	assign led_gap     = (center_x > led_x) ? center_x - led_x : led_x - center_x;
	assign delay       = (DIST_W+DUR_W)'(led_gap) * (DIST_W+DUR_W)'(step_q);
	assign press_start = now_q + TIME_W'(delay);

	// An LED is lit once started and until its duration has run out.
	assign started = mem_rdata.live && !(now_q < mem_rdata.start);
	assign elapsed = now_q - mem_rdata.start;
	assign expire  = started && (elapsed >= TIME_W'(dur_q));
	assign lit     = started && !expire;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (item.valid) begin
					state_d = (item.cmd == CMD_PRESS) ? S_PRESS : S_WAVE;
				end
			end
			S_PRESS: begin
				if (last_led) begin
					state_d = S_IDLE;
				end
			end
			S_WAVE: begin
				if (wave_live_q[slot_q]) begin
					state_d = S_READ;
				end else if (last_slot) begin
					state_d = S_DONE;
				end
			end
			S_READ: begin
				state_d = S_EVAL;
			end
			S_EVAL, S_ENV: begin
				if (state_q == S_EVAL && lit) begin
					state_d = S_ENV;
				end else if (state_q == S_EVAL || env_stat.done) begin
					if (!last_led) begin
						state_d = S_READ;
					end else if (last_slot) begin
						state_d = S_DONE;
					end else begin
						state_d = S_WAVE;
					end
				end
			end
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		item_ready = 1'b0;
		mem_we     = 1'b0;
		mem_re     = 1'b0;
		env_start  = 1'b0;
		adv        = 1'b0;
		load_out   = 1'b0;
		mem_wdata  = '{live: 1'b0, start: mem_rdata.start};
		case (state_q)
			S_IDLE: begin
				item_ready = 1'b1;
			end
			S_PRESS: begin
				mem_we    = 1'b1;
				mem_wdata = '{live: 1'b1, start: press_start};
			end
			S_READ: begin
				mem_re = 1'b1;
			end
			S_EVAL: begin
				mem_we    = expire;
				env_start = lit;
				adv       = !lit;
			end
			S_ENV: begin
				adv = env_stat.done;
			end
			S_DONE: begin
				load_out = out_free;
			end
			default: begin
				item_ready = 1'b0;
			end
		endcase
	end

	// State, counters, wave flags and configuration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			mb_q        <= MAX_BRIGHTNESS_RST;
			dur_q       <= WAVE_DURATION_RST;
			step_q      <= STEP_DELAY_RST;
			slot_q      <= '0;
			led_q       <= '0;
			cell_q      <= '0;
			any_on_q    <= 1'b0;
			wave_live_q <= '0;
			next_slot_q <= '0;
			next_base_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;

			// Register writes.
			if (cfg.valid) begin
				case (cfg.index)
					REG_MAX_BRIGHTNESS: mb_q   <= cfg.data[LEVEL_W-1:0];
					REG_WAVE_DURATION:  dur_q  <= cfg.data;
					REG_STEP_DELAY:     step_q <= cfg.data;
					default:            mb_q   <= mb_q;
				endcase
			end

			// Start of a word: point at the slot to fill or at the first slot.
			if (state_q == S_IDLE && item.valid) begin
				slot_q   <= '0;
				led_q    <= '0;
				any_on_q <= 1'b0;
				cell_q   <= (item.cmd == CMD_PRESS) ? next_base_q : '0;
			end

			// Press: one LED a cycle, then claim the slot.
			if (state_q == S_PRESS) begin
				if (last_led) begin
					wave_live_q[next_slot_q] <= 1'b1;
					if (next_slot_q == SLOT_W'(WAVE_SLOTS - 1)) begin
						next_slot_q <= '0;
						next_base_q <= '0;
					end else begin
						next_slot_q <= next_slot_q + 1'b1;
						next_base_q <= next_base_q + CELL_W'(LED_COUNT);
					end
				end else begin
					led_q  <= led_q + 1'b1;
					cell_q <= cell_q + 1'b1;
				end
			end

			// Wave entry: walk its LEDs or skip the whole slot.
			if (state_q == S_WAVE) begin
				led_q    <= '0;
				any_on_q <= 1'b0;
				if (!wave_live_q[slot_q]) begin
					cell_q <= cell_q + CELL_W'(LED_COUNT);
					slot_q <= slot_q + 1'b1;
				end
			end

			if (env_start) begin
				any_on_q <= 1'b1;
			end

			// Move to the next LED; retire the wave if none of its LEDs was lit.
			if (adv) begin
				cell_q <= cell_q + 1'b1;
				if (last_led) begin
					if (!any_on_q) begin
						wave_live_q[slot_q] <= 1'b0;
					end
					slot_q <= slot_q + 1'b1;
				end else begin
					led_q <= led_q + 1'b1;
				end
			end

			// Output register handshake.
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Final level per output: the ripple peak maxed with the base level.
	for (genvar g = 0; g < OUT_LEDS; g++) begin : g_out
		if (g < LED_COUNT) begin : g_led
			assign out_level_d[g] = (level_q[g] > base_q[g]) ? level_q[g] : base_q[g];
		end else begin : g_base
			assign out_level_d[g] = base_q[g];
		end
	end

	// Payload registers: latched word, per-LED peaks and result levels.
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && item.valid) begin
			cmd_q     <= item.cmd;
			now_q     <= item.now_ms;
			center_q  <= item.center;
			base_q[0] <= item.base_level_0;
			base_q[1] <= item.base_level_1;
			base_q[2] <= item.base_level_2;
			for (int i = 0; i < LED_COUNT; i++) begin
				level_q[i] <= '0;
			end
		end
		if (state_q == S_ENV && env_stat.done && env_value > level_q[led_q]) begin
			level_q[led_q] <= env_value;
		end
		if (load_out) begin
			for (int i = 0; i < OUT_LEDS; i++) begin
				out_level_q[i] <= out_level_d[i];
			end
		end
	end

	// Per-LED store.
	rwle_mem #(
		.DEPTH  (CELLS),
		.ADDR_W (CELL_W)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (cell_q),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (cell_q),
		.rdata (mem_rdata)
	);

	// Shared multiply and divide unit.
	rwle_env u_env (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (env_start),
		.elapsed (elapsed[DUR_W-1:0]),
		.dur     (dur_q),
		.mb      (mb_q),
		.stat    (env_stat),
		.value   (env_value)
	);

	// Port drive.
	assign item.ready     = item_ready;
	assign cfg.ready      = 1'b1;
	assign result.valid   = out_valid_q;
	assign result.level_0 = out_level_q[0];
	assign result.level_1 = out_level_q[1];
	assign result.level_2 = out_level_q[2];

	// A result word appears only when the finished tick leaves its last state.
	a_result_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_DONE))
		else $error("result word raised outside the done state");

	// An accepted word starts the matching walk.
	a_word_dispatch: assert property (@(posedge clk) disable iff (!arst_n)
		(item.valid && item.ready) |=>
		((state_q == S_PRESS && cmd_q == CMD_PRESS) ||
		(state_q == S_WAVE && cmd_q == CMD_TICK)))
		else $error("accepted word did not start the matching walk");

	// The envelope unit only runs while the sequencer waits for it.
	a_env_owned: assert property (@(posedge clk) disable iff (!arst_n)
		env_stat.busy |-> state_q == S_ENV)
		else $error("envelope unit busy outside the wait state");

	// An envelope value never exceeds the peak brightness.
	a_env_bound: assert property (@(posedge clk) disable iff (!arst_n)
		env_stat.done |-> env_value <= mb_q)
		else $error("envelope value above peak brightness");

	// The slot pointer and its store base stay in step.
	a_ring_base: assert property (@(posedge clk) disable iff (!arst_n)
		next_base_q == CELL_W'(int'(next_slot_q) * LED_COUNT))
		else $error("ring pointer and store base disagree");

endmodule

// ----- design/rwle_mem.sv -----
// ----------------------------------------------------------------------------
// rwle_mem: per-LED store of live flags and start times
// One write port and one read port with registered read data. Entries hold
// nothing meaningful until written; the wave flags gate every read.
// ----------------------------------------------------------------------------
module rwle_mem #(
	parameter int DEPTH  = 24,
	parameter int ADDR_W = 5
) (
	input  logic                clk,
	input  logic                we,
	input  logic [ADDR_W-1:0]   waddr,
	input  rwle_pkg::cell_t     wdata,
	input  logic                re,
	input  logic [ADDR_W-1:0]   raddr,
	output rwle_pkg::cell_t     rdata
);
	import rwle_pkg::*;

	cell_t mem_q [DEPTH];
	cell_t rdata_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- design/rwle_env.sv -----
// ----------------------------------------------------------------------------
// rwle_env: triangular envelope unit
// Computes one envelope value from the elapsed time: a multiply step, then a
// restoring divide by half the duration (skipped when it is zero), one quotient bit a cycle.
// ----------------------------------------------------------------------------
module rwle_env (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [rwle_pkg::DUR_W-1:0]    elapsed,
	input  logic [rwle_pkg::DUR_W-1:0]    dur,
	input  logic [rwle_pkg::LEVEL_W-1:0]  mb,
	output rwle_pkg::env_stat_t           stat,
	output logic [rwle_pkg::LEVEL_W-1:0]  value
);
	import rwle_pkg::*;

	env_state_t state_q, state_d;

	logic               rising_q;
	logic [DUR_W-2:0]   half_q;
	logic [DUR_W-1:0]   e_q;
	logic [LEVEL_W-1:0] mbv_q;
	logic [PROD_W-1:0]  rem_q;
	logic [PROD_W-1:0]  div_q;
	logic [QUO_W-1:0]   quo_q;
	logic [QCNT_W-1:0]  k_q;

	logic [DUR_W-2:0]   half_in;
	logic               rising_in;
	logic               ge;

	// Split the elapsed time into the rising or the falling half.
	assign half_in   = dur[DUR_W-1:1];
	assign rising_in = elapsed < {1'b0, half_in};
	assign ge        = rem_q >= div_q;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			E_IDLE: begin
				if (start) begin
					state_d = E_MUL;
				end
			end
			E_MUL: begin
				state_d = (half_q == '0) ? E_FIN : E_DIV;
			end
			E_DIV: begin
				if (k_q == '0) begin
					state_d = E_FIN;
				end
			end
			E_FIN: begin
				state_d = E_IDLE;
			end
			default: begin
				state_d = E_IDLE;
			end
		endcase
	end

	// Outputs.
	always_comb begin
		stat.busy = 1'b0;
		stat.done = 1'b0;
		value     = rising_q ? quo_q : mbv_q - quo_q;
		case (state_q)
			E_IDLE: begin
				stat.busy = 1'b0;
			end
			E_MUL, E_DIV: begin
				stat.busy = 1'b1;
			end
			E_FIN: begin
				stat.busy = 1'b1;
				stat.done = 1'b1;
			end
			default: begin
				stat.busy = 1'b0;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= E_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Operand capture, multiply and divide steps.
	always_ff @(posedge clk) begin
		case (state_q)
			E_IDLE: begin
				if (start) begin
					half_q   <= half_in;
					rising_q <= rising_in;
					e_q      <= rising_in ? elapsed : elapsed - {1'b0, half_in};
					mbv_q    <= mb;
				end
			end
			E_MUL: begin
				rem_q <= PROD_W'(e_q) * PROD_W'(mbv_q);
				div_q <= PROD_W'({half_q, {(QUO_W-1){1'b0}}});
				quo_q <= '0;
				k_q   <= QCNT_W'(QUO_W - 1);
			end
			E_DIV: begin
				if (ge) begin
					rem_q <= rem_q - div_q;
				end
				quo_q <= {quo_q[QUO_W-2:0], ge};
				div_q <= div_q >> 1;
				k_q   <= k_q - 1'b1;
			end
			default: begin
				k_q <= k_q;
			end
		endcase
	end

endmodule

// ----- bench/ripple_wave_led_envelope_tb.sv -----
// ----------------------------------------------------------------------------
// ripple_wave_led_envelope_tb: self-checking bench for the ripple LED engine
// Drives press and tick words into the block, keeps its own copy of the wave
// ring and LED start times, predicts the LED levels of every tick and checks
// each result word in order. Directed words cover the register corners, time
// wrap, waiting LEDs and the center value 3; random phases follow, each with
// new register settings and given rates of sender and receiver gaps.
// ----------------------------------------------------------------------------
module ripple_wave_led_envelope_tb;
	import rwle_pkg::*;

	localparam int SLOTS = WAVE_SLOTS_DEF;
	localparam int LEDS  = LED_COUNT_DEF;
	localparam int CELLS = SLOTS * LEDS;
	// Index with no register behind it; a write there changes nothing.
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	typedef struct packed {
		logic                cmd;
		logic [TIME_W-1:0]   now_ms;
		logic [CENTER_W-1:0] center;
		logic [LEVEL_W-1:0]  base_0;
		logic [LEVEL_W-1:0]  base_1;
		logic [LEVEL_W-1:0]  base_2;
	} key_event_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] led_0;
		logic [LEVEL_W-1:0] led_1;
		logic [LEVEL_W-1:0] led_2;
	} led_levels_t;

	logic clk = 1'b0;
	logic arst_n;

	rwle_item_if   item();
	rwle_result_if result();
	rwle_cfg_if    cfg();

	ripple_wave_led_envelope u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.result (result),
		.cfg    (cfg)
	);

	// Shadow registers and wave store of the block.
	logic [LEVEL_W-1:0] peak_level;
	logic [DUR_W-1:0]   duration_ms;
	logic [DUR_W-1:0]   delay_ms;
	bit                 wave_on [SLOTS];
	bit                 led_on [CELLS];
	logic [TIME_W-1:0]  led_start [CELLS];
	int                 ring_ptr;

	led_levels_t        pending_levels [$];
	led_levels_t        oldest_levels;
	int                 mismatches = 0;
	int                 src_idle_pct = 0;
	int                 snk_stall_pct = 0;
	logic [TIME_W-1:0]  wall_ms;

	always #5 clk = ~clk;

	// Triangle envelope of one LED at a given time since its start.
	function automatic logic [LEVEL_W-1:0] triangle_level(input logic [TIME_W-1:0] elapsed);
		logic [31:0] half;
		logic [31:0] pk;
		logic [31:0] q;
		logic [31:0] v;
		half = {16'd0, duration_ms} >> 1;
		pk = {24'd0, peak_level};
		if (elapsed < half) begin
			v = (elapsed * pk) / half;
		end else begin
			// With a half length of zero the falling ramp stays at the peak.
			q = (half != 0) ? ((elapsed - half) * pk) / half : 32'd0;
			v = pk - q;
		end
		return v[LEVEL_W-1:0];
	endfunction

	// Apply one accepted word to the shadow store; a tick queues its levels.
	task automatic track_ripple(input key_event_t ev);
		int                 w;
		int                 i;
		int                 c;
		int                 cpos;
		logic [TIME_W-1:0]  gap;
		logic [TIME_W-1:0]  elapsed;
		logic [LEVEL_W-1:0] v;
		logic [LEVEL_W-1:0] lit [LEDS];
		logic [LEVEL_W-1:0] base [OUT_LEDS];
		logic [LEVEL_W-1:0] outv [OUT_LEDS];
		bit                 any_lit;
		led_levels_t        lv;
		if (ev.cmd == CMD_PRESS) begin
			cpos = int'(ev.center);
			wave_on[ring_ptr] = 1'b1;
			for (i = 0; i < LEDS; i++) begin
				gap = (cpos > i) ? cpos - i : i - cpos;
				c = ring_ptr * LEDS + i;
				led_on[c] = 1'b1;
				led_start[c] = ev.now_ms + gap * {16'd0, delay_ms};
			end
			ring_ptr = (ring_ptr + 1) % SLOTS;
		end else begin
			for (i = 0; i < LEDS; i++) lit[i] = '0;
			for (w = 0; w < SLOTS; w++) begin
				if (wave_on[w]) begin
					any_lit = 1'b0;
					for (i = 0; i < LEDS; i++) begin
						c = w * LEDS + i;
						// Unsigned compare: an LED whose start lies ahead waits.
						if (led_on[c] && ev.now_ms >= led_start[c]) begin
							elapsed = ev.now_ms - led_start[c];
							if (elapsed >= {16'd0, duration_ms}) begin
								led_on[c] = 1'b0;
							end else begin
								v = triangle_level(elapsed);
								if (v > lit[i]) lit[i] = v;
								any_lit = 1'b1;
							end
						end
					end
					if (!any_lit) wave_on[w] = 1'b0;
				end
			end
			base[0] = ev.base_0;
			base[1] = ev.base_1;
			base[2] = ev.base_2;
			for (i = 0; i < OUT_LEDS; i++) begin
				outv[i] = base[i];
				if (i < LEDS && lit[i] > outv[i]) outv[i] = lit[i];
			end
			lv.led_0 = outv[0];
			lv.led_1 = outv[1];
			lv.led_2 = outv[2];
			pending_levels.push_back(lv);
		end
	endtask

	// Send one word on the item channel, with random sender gaps.
	task automatic send_word(input key_event_t ev);
		@(negedge clk);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			item.valid <= 1'b0;
			@(negedge clk);
		end
		item.valid        <= 1'b1;
		item.cmd          <= ev.cmd;
		item.now_ms       <= ev.now_ms;
		item.center       <= ev.center;
		item.base_level_0 <= ev.base_0;
		item.base_level_1 <= ev.base_1;
		item.base_level_2 <= ev.base_2;
		do @(posedge clk); while (item.ready !== 1'b1);
		track_ripple(ev);
	endtask

	task automatic press_key(input logic [TIME_W-1:0] t, input logic [CENTER_W-1:0] ctr);
		key_event_t ev;
		ev = '0;
		ev.cmd = CMD_PRESS;
		ev.now_ms = t;
		ev.center = ctr;
		send_word(ev);
	endtask

	task automatic tick_at(input logic [TIME_W-1:0] t, input logic [LEVEL_W-1:0] b0,
		input logic [LEVEL_W-1:0] b1, input logic [LEVEL_W-1:0] b2);
		key_event_t ev;
		ev = '0;
		ev.cmd = CMD_TICK;
		ev.now_ms = t;
		ev.base_0 = b0;
		ev.base_1 = b1;
		ev.base_2 = b2;
		send_word(ev);
	endtask

	// Register write on the configuration channel.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= data;
		do @(posedge clk); while (cfg.ready !== 1'b1);
		case (idx)
			REG_MAX_BRIGHTNESS: peak_level = data[LEVEL_W-1:0];
			REG_WAVE_DURATION:  duration_ms = data;
			REG_STEP_DELAY:     delay_ms = data;
			default: ;
		endcase
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	// Wait until every tick has answered and a trailing press has finished.
	task automatic settle_block();
		@(negedge clk);
		item.valid <= 1'b0;
		while (pending_levels.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	// Register defaults: waves from every center, waiting LEDs, peak and end.
	task automatic test_default_registers();
		tick_at(32'd0, 8'hFF, 8'h00, 8'hA5);
		press_key(32'd1000, 2'd0);
		tick_at(32'd1000, 8'h00, 8'h00, 8'h00);
		tick_at(32'd1125, 8'h00, 8'h00, 8'h00);
		tick_at(32'd1250, 8'h00, 8'hFF, 8'h00);
		tick_at(32'd1499, 8'h00, 8'h00, 8'h00);
		tick_at(32'd1500, 8'h10, 8'h00, 8'h00);
		press_key(32'd1600, 2'd3);
		tick_at(32'd1750, 8'h00, 8'h00, 8'h00);
		tick_at(32'd2000, 8'h00, 8'h00, 8'h00);
		// A wave whose LEDs have not yet started is dropped at once.
		press_key(32'd3000, 2'd3);
		tick_at(32'd3000, 8'h00, 8'h00, 8'h00);
		tick_at(32'd3400, 8'h00, 8'h00, 8'h00);
		press_key(32'd4000, 2'd2);
		press_key(32'd4000, 2'd1);
		tick_at(32'd4100, 8'h00, 8'h00, 8'h00);
		tick_at(32'd4400, 8'h00, 8'h00, 8'h00);
	endtask

	// Start times that wrap past the top of the time counter.
	task automatic test_time_wrap();
		press_key(32'hFFFF_FF00, 2'd2);
		tick_at(32'hFFFF_FFFF, 8'h00, 8'h00, 8'h00);
		tick_at(32'h0000_0010, 8'h00, 8'h00, 8'h00);
		press_key(32'hFFFF_FFFF, 2'd1);
		tick_at(32'hFFFF_FFFF, 8'hFF, 8'hFF, 8'hFF);
	endtask

	// Durations of zero and one, a peak of zero and the largest settings.
	task automatic test_register_corners();
		settle_block();
		write_reg(REG_WAVE_DURATION, 16'd0);
		press_key(32'd5000, 2'd1);
		tick_at(32'd5000, 8'h00, 8'h00, 8'h00);
		settle_block();
		write_reg(REG_WAVE_DURATION, 16'd1);
		write_reg(REG_STEP_DELAY, 16'd0);
		press_key(32'd6000, 2'd0);
		tick_at(32'd6000, 8'h00, 8'h00, 8'h00);
		tick_at(32'd6001, 8'h00, 8'h00, 8'h00);
		settle_block();
		write_reg(REG_MAX_BRIGHTNESS, 16'hFF00);
		write_reg(REG_WAVE_DURATION, 16'd2);
		write_reg(REG_UNUSED, 16'hFFFF);
		press_key(32'd7000, 2'd2);
		tick_at(32'd7000, 8'h00, 8'h00, 8'h00);
		settle_block();
		write_reg(REG_MAX_BRIGHTNESS, 16'h00FF);
		write_reg(REG_WAVE_DURATION, 16'hFFFF);
		write_reg(REG_STEP_DELAY, 16'hFFFF);
		press_key(32'd8000, 2'd0);
		tick_at(32'd40767, 8'h00, 8'h00, 8'h00);
		tick_at(32'd108000, 8'h00, 8'h00, 8'h00);
	endtask

	// One random phase: new registers, then press and tick words on a
	// running time base, with a few words at stray times.
	task automatic test_random_traffic(input int count, input int src_pct, input int snk_pct,
		input logic [LEVEL_W-1:0] pk, input logic [DUR_W-1:0] dur, input logic [DUR_W-1:0] step);
		key_event_t                ev;
		logic [CFG_DATA_W-1:0]     pk_word;
		int                        n;
		int                        roll;
		int                        span;
		settle_block();
		pk_word = CFG_DATA_W'($urandom);
		pk_word[LEVEL_W-1:0] = pk;
		write_reg(REG_MAX_BRIGHTNESS, pk_word);
		write_reg(REG_WAVE_DURATION, dur);
		write_reg(REG_STEP_DELAY, step);
		src_idle_pct = src_pct;
		snk_stall_pct = snk_pct;
		span = (int'(dur) + int'(step)) / 8 + 2;
		wall_ms = $urandom;
		for (n = 0; n < count; n++) begin
			roll = $urandom_range(0, 99);
			if (roll < 3) wall_ms = $urandom;
			else wall_ms += $urandom_range(0, span);
			ev.cmd = ($urandom_range(0, 99) < 30) ? CMD_PRESS : CMD_TICK;
			ev.now_ms = (roll >= 97) ? $urandom : wall_ms;
			ev.center = CENTER_W'($urandom_range(0, 3));
			ev.base_0 = ($urandom_range(0, 2) == 0) ? LEVEL_W'($urandom) : 8'd0;
			ev.base_1 = ($urandom_range(0, 2) == 0) ? LEVEL_W'($urandom) : 8'd0;
			ev.base_2 = ($urandom_range(0, 2) == 0) ? LEVEL_W'($urandom) : 8'd0;
			send_word(ev);
		end
		src_idle_pct = 0;
		snk_stall_pct = 0;
	endtask

	task automatic check_level(input string name, input logic [LEVEL_W-1:0] want,
		input logic [LEVEL_W-1:0] got);
		if (got !== want) begin
			mismatches++;
			$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
		end
	endtask

	// Result receiver: random stalls on ready.
	always @(negedge clk) begin
		result.ready <= arst_n && ($urandom_range(0, 99) >= snk_stall_pct);
	end

	// Compare every result word with the oldest predicted levels.
	always @(posedge clk) begin
		if (arst_n && result.valid === 1'b1 && result.ready === 1'b1) begin
			if (pending_levels.size() == 0) begin
				mismatches++;
				$display("%0t: expected no result, got %0d %0d %0d", $time,
					result.level_0, result.level_1, result.level_2);
			end else begin
				oldest_levels = pending_levels.pop_front();
				check_level("level_0", oldest_levels.led_0, result.level_0);
				check_level("level_1", oldest_levels.led_1, result.level_1);
				check_level("level_2", oldest_levels.led_2, result.level_2);
			end
		end
	end

	// Main sequence.
	initial begin
		arst_n = 1'b0;
		item.valid = 1'b0;
		item.cmd = CMD_TICK;
		item.now_ms = '0;
		item.center = '0;
		item.base_level_0 = '0;
		item.base_level_1 = '0;
		item.base_level_2 = '0;
		cfg.valid = 1'b0;
		cfg.index = REG_MAX_BRIGHTNESS;
		cfg.data = '0;
		peak_level = MAX_BRIGHTNESS_RST;
		duration_ms = WAVE_DURATION_RST;
		delay_ms = STEP_DELAY_RST;
		for (int k = 0; k < SLOTS; k++) wave_on[k] = 1'b0;
		for (int k = 0; k < CELLS; k++) begin
			led_on[k] = 1'b0;
			led_start[k] = '0;
		end
		ring_ptr = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_default_registers();
		test_time_wrap();
		test_register_corners();
		test_random_traffic(140, 0, 0, 8'd255, 16'd2, 16'd0);
		test_random_traffic(140, 81, 0, LEVEL_W'($urandom), DUR_W'($urandom_range(2, 600)),
			DUR_W'($urandom_range(0, 300)));
		test_random_traffic(140, 0, 81, 8'd255, 16'hFFFF, 16'hFFFF);
		test_random_traffic(140, 26, 26, LEVEL_W'($urandom), DUR_W'($urandom_range(2, 2000)),
			DUR_W'($urandom_range(0, 1000)));
		test_random_traffic(140, 0, 0, 8'd1, 16'd3, 16'd1);

		settle_block();
		repeat (400) @(posedge clk);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Watchdog against a hung handshake.
	initial begin
		#20000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ----- files.f -----
design/rwle_pkg.sv
design/rwle_if.sv
design/rwle_mem.sv
design/rwle_env.sv
design/ripple_wave_led_envelope.sv
bench/ripple_wave_led_envelope_tb.sv
